### src/lirr_pkg.sv
`timescale 1ns / 1ps
// Package for the linear interpolation rate resampler.
// Default sizes and sequencer states; no dependencies.
package lirr_pkg;

    localparam int LIRR_SAMPLE_BITS = 24;
    localparam int LIRR_FRAC_BITS   = 16;
    localparam int LIRR_MAX_RUN     = 1048576;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WCHK,
        S_LCHK,
        S_MUL,
        S_LERP,
        S_POST,
        S_TAIL,
        S_FINAL
    } lirr_state_t;

endpackage

### src/linear_interp_rate_resampler_core.sv
`timescale 1ns / 1ps
// Linear interpolation sample rate converter, top level.
// Depends on lirr_pkg for default sizes and the sequencer state type.

// Resamples a run of signed samples (s_axis, tlast on the final sample) by the
// unsigned Q4.FRAC_BITS step in the configuration register (clamped to 0.1..10,
// reset 1.0). Output n sits at input position n*ratio; a run of L samples gives
// round(L/ratio) beats, at least one, the last marked by tlast, tuser carrying
// the overrun flag. Beats go out one late, so the final one can carry tlast.
// One input beat is taken at a time: the next is not accepted until the
// small sequencer has stepped the single multiplier and the existence
// comparator over every output of the last one, and output stalls hold
// the sequencer. Runs longer than MAX_RUN samples drop the excess and
// raise the overrun flag. Ratio writes are taken only while no input beat is
// in flight or offered.
module linear_interp_rate_resampler_core
    import lirr_pkg::*;
#(
    parameter int SAMPLE_BITS = LIRR_SAMPLE_BITS,
    parameter int FRAC_BITS   = LIRR_FRAC_BITS,
    parameter int MAX_RUN     = LIRR_MAX_RUN
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [FRAC_BITS+3:0]                   cfg_data,       // rate_ratio
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,   // in_sample
    input  logic                                   s_axis_tlast,   // in_last
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_axis_tdata,   // out_sample
    output logic                                   m_axis_tlast,   // out_last
    output logic                                   m_axis_tuser    // overrun
);

    localparam int TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int CNT_W    = $clog2(MAX_RUN + 1);
    localparam int POS_W    = CNT_W + FRAC_BITS + 1;
    localparam int CMP_W    = POS_W + 2;
    localparam int RATE_W   = FRAC_BITS + 4;
    localparam int PROD_W   = SAMPLE_BITS + FRAC_BITS + 2;
    localparam int RATE_MIN = ((1 << FRAC_BITS) + 5) / 10;
    localparam int RATE_MAX = 10 << FRAC_BITS;
    localparam int RATE_ONE = 1 << FRAC_BITS;
    localparam int HALF     = 1 << (FRAC_BITS - 1);

    lirr_state_t state_reg, state_next;

    logic [RATE_W-1:0]      rate_reg, rate_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       known_reg, known_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic                   ovr_reg, ovr_next;
    logic                   wait_valid_reg, wait_valid_next;
    logic                   held_valid_reg, held_valid_next;
    logic                   out_valid_reg, out_valid_next;

    logic [SAMPLE_BITS-1:0] prev_reg, prev_next;
    logic [SAMPLE_BITS-1:0] cur_reg, cur_next;
    logic                   last_reg, last_next;
    logic                   acc_reg, acc_next;
    logic [SAMPLE_BITS-1:0] wait_val_reg, wait_val_next;
    logic [POS_W-1:0]       wait_pos_reg, wait_pos_next;
    logic [SAMPLE_BITS-1:0] held_val_reg, held_val_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [SAMPLE_BITS-1:0] out_sample_reg, out_sample_next;
    logic                   out_last_reg, out_last_next;
    logic                   out_ovr_reg, out_ovr_next;

    // shared arithmetic
    logic [POS_W-1:0]         chk_pos;
    logic [CNT_W-1:0]         chk_len;
    logic [CMP_W-1:0]         ex_lhs;
    logic [CMP_W-1:0]         ex_rhs;
    logic                     exists_ok;
    logic                     below;
    logic [POS_W-1:0]         pos_step;
    logic signed [SAMPLE_BITS:0] diff_s;
    logic signed [FRAC_BITS:0]   frac_s;
    logic signed [PROD_W-1:0] mul_res;
    logic signed [PROD_W-1:0] lerp_sum;
    logic signed [PROD_W-1:0] lerp_shr;
    logic [SAMPLE_BITS-1:0]   lerp_v;
    logic [CNT_W:0]           after_ext;
    logic [CNT_W:0]           known_raw;
    logic                     acc_now;
    logic                     put_ok;
    logic                     push_block;
    logic [SAMPLE_BITS-1:0]   tail_v;

    assign chk_pos   = (state_reg == S_WCHK) ? wait_pos_reg : pos_reg;
    assign chk_len   = (state_reg == S_TAIL) ? count_reg : known_reg;
    assign ex_lhs    = CMP_W'({chk_pos, 1'b0}) + CMP_W'(rate_reg);
    assign ex_rhs    = CMP_W'({chk_len, {(FRAC_BITS + 1){1'b0}}});
    assign exists_ok = (chk_pos == '0) || (ex_lhs <= ex_rhs);
    assign below     = pos_reg < POS_W'({count_reg, {FRAC_BITS{1'b0}}});
    assign pos_step  = pos_reg + POS_W'(rate_reg);

    assign diff_s   = $signed({cur_reg[SAMPLE_BITS-1], cur_reg})
                    - $signed({prev_reg[SAMPLE_BITS-1], prev_reg});
    assign frac_s   = $signed({1'b0, pos_reg[FRAC_BITS-1:0]});
    assign mul_res  = diff_s * frac_s;
    assign lerp_sum = prod_reg + $signed(PROD_W'(HALF));
    assign lerp_shr = lerp_sum >>> FRAC_BITS;
    assign lerp_v   = prev_reg + lerp_shr[SAMPLE_BITS-1:0];
    assign tail_v   = below ? prev_reg : '0;

    assign acc_now   = count_reg < CNT_W'(MAX_RUN);
    assign after_ext = {1'b0, count_reg} + (CNT_W + 1)'(acc_now);
    assign known_raw = after_ext + (CNT_W + 1)'(!s_axis_tlast);

    assign put_ok     = !out_valid_reg || m_axis_tready;
    assign push_block = held_valid_reg && !put_ok;

    // input beats win over a ratio write offered in the same cycle
    assign cfg_ready     = (state_reg == S_IDLE) && !s_axis_tvalid;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_W'(out_sample_reg);
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_ovr_reg;

    always_comb
    begin
        state_next      = state_reg;
        rate_next       = rate_reg;
        count_next      = count_reg;
        known_next      = known_reg;
        pos_next        = pos_reg;
        ovr_next        = ovr_reg;
        wait_valid_next = wait_valid_reg;
        held_valid_next = held_valid_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        prev_next       = prev_reg;
        cur_next        = cur_reg;
        last_next       = last_reg;
        acc_next        = acc_reg;
        wait_val_next   = wait_val_reg;
        wait_pos_next   = wait_pos_reg;
        held_val_next   = held_val_reg;
        prod_next       = prod_reg;
        out_sample_next = out_sample_reg;
        out_last_next   = out_last_reg;
        out_ovr_next    = out_ovr_reg;

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_data < RATE_W'(RATE_MIN))
                rate_next = RATE_W'(RATE_MIN);
            else if (cfg_data > RATE_W'(RATE_MAX))
                rate_next = RATE_W'(RATE_MAX);
            else
                rate_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cur_next  = s_axis_tdata[SAMPLE_BITS-1:0];
                    last_next = s_axis_tlast;
                    acc_next  = acc_now;
                    if (known_raw > (CNT_W + 1)'(MAX_RUN))
                        known_next = CNT_W'(MAX_RUN);
                    else
                        known_next = known_raw[CNT_W-1:0];
                    state_next = S_WCHK;
                end
            end
            S_WCHK:
            begin
                if (!(wait_valid_reg && exists_ok && push_block))
                begin
                    if (wait_valid_reg && exists_ok)
                    begin
                        if (held_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_sample_next = held_val_reg;
                            out_last_next   = 1'b0;
                            out_ovr_next    = ovr_reg;
                        end
                        held_val_next   = wait_val_reg;
                        held_valid_next = 1'b1;
                        wait_valid_next = 1'b0;
                    end
                    state_next = acc_reg ? S_LCHK : S_POST;
                end
            end
            S_LCHK:
            begin
                state_next = below ? S_MUL : S_POST;
            end
            S_MUL:
            begin
                prod_next  = mul_res;
                state_next = S_LERP;
            end
            S_LERP:
            begin
                if (exists_ok)
                begin
                    if (!push_block)
                    begin
                        if (held_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_sample_next = held_val_reg;
                            out_last_next   = 1'b0;
                            out_ovr_next    = ovr_reg;
                        end
                        held_val_next   = lerp_v;
                        held_valid_next = 1'b1;
                        pos_next        = pos_step;
                        state_next      = S_LCHK;
                    end
                end
                else
                begin
                    if (!last_reg)
                    begin
                        wait_val_next   = lerp_v;
                        wait_pos_next   = pos_reg;
                        wait_valid_next = 1'b1;
                    end
                    pos_next   = pos_step;
                    state_next = S_LCHK;
                end
            end
            S_POST:
            begin
                if (acc_reg)
                begin
                    prev_next  = cur_reg;
                    count_next = count_reg + 1'b1;
                end
                else
                    ovr_next = 1'b1;
                if (last_reg)
                begin
                    wait_valid_next = 1'b0;
                    state_next      = S_TAIL;
                end
                else
                    state_next = S_IDLE;
            end
            S_TAIL:
            begin
                if (exists_ok)
                begin
                    if (!push_block)
                    begin
                        if (held_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_sample_next = held_val_reg;
                            out_last_next   = 1'b0;
                            out_ovr_next    = ovr_reg;
                        end
                        held_val_next   = tail_v;
                        held_valid_next = 1'b1;
                        pos_next        = pos_step;
                    end
                end
                else
                    state_next = S_FINAL;
            end
            S_FINAL:
            begin
                if (put_ok || !held_valid_reg)
                begin
                    if (held_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_sample_next = held_val_reg;
                        out_last_next   = 1'b1;
                        out_ovr_next    = ovr_reg;
                    end
                    held_valid_next = 1'b0;
                    wait_valid_next = 1'b0;
                    count_next      = '0;
                    pos_next        = '0;
                    ovr_next        = 1'b0;
                    prev_next       = '0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rate_reg       <= RATE_W'(RATE_ONE);
            count_reg      <= '0;
            known_reg      <= '0;
            pos_reg        <= '0;
            ovr_reg        <= 1'b0;
            wait_valid_reg <= 1'b0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rate_reg       <= rate_next;
            count_reg      <= count_next;
            known_reg      <= known_next;
            pos_reg        <= pos_next;
            ovr_reg        <= ovr_next;
            wait_valid_reg <= wait_valid_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg       <= prev_next;
        cur_reg        <= cur_next;
        last_reg       <= last_next;
        acc_reg        <= acc_next;
        wait_val_reg   <= wait_val_next;
        wait_pos_reg   <= wait_pos_next;
        held_val_reg   <= held_val_next;
        prod_reg       <= prod_next;
        out_sample_reg <= out_sample_next;
        out_last_reg   <= out_last_next;
        out_ovr_reg    <= out_ovr_next;
    end

`ifndef SYNTHESIS
    a_ovr_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        ovr_reg |-> (count_reg == CNT_W'(MAX_RUN)))
        else $error("overrun flag set below run limit");

    a_held_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && held_valid_reg) |-> (count_reg > CNT_W'(1)))
        else $error("held output before two samples");

    a_pos_caught_up: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && count_reg != '0)
        |-> (pos_reg >= POS_W'({CNT_W'(count_reg - 1'b1), {FRAC_BITS{1'b0}}})))
        else $error("position behind last interval");

    a_empty_run_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && count_reg == '0)
        |-> (!wait_valid_reg && !held_valid_reg && pos_reg == '0))
        else $error("run state not cleared");
`endif

endmodule
